>>> rtl/core/sbda_pkg.sv
// Shared types, constants and helpers for the signed binary to decimal ASCII converter.
`default_nettype none
package sbda_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int CHAR_W          = 7;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;

  // decimal digits needed for 2^(w-1), the largest magnitude at width w
  function automatic int dec_digits(input int w);
    logic [64:0] v;
    int          n;
    v = 65'd1 << (w - 1);
    n = 0;
    for (int i = 0; i < 21; i++) begin
      if (v != 65'd0) begin
        v = v / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic neg;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/sbda_ctrl.sv
// Sequencer for load, shift-add-3 conversion, leading-zero skip and character output.
`default_nettype none
module sbda_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sbda_pkg::dp_stat_t  stat,
  output sbda_pkg::ctrl_cmd_t      cmd
);

  sbda_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sbda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sbda_pkg::ST_CONV;
        end
      end
      sbda_pkg::ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_done) begin
          state_nxt = sbda_pkg::ST_SKIP;
        end
      end
      sbda_pkg::ST_SKIP: begin
        if (stat.top_zero && !stat.one_left) begin
          cmd.skip = 1'b1;
        end else if (stat.neg) begin
          state_nxt = sbda_pkg::ST_SIGN;
        end else begin
          state_nxt = sbda_pkg::ST_DIGIT;
        end
      end
      sbda_pkg::ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = sbda_pkg::ST_DIGIT;
        end
      end
      sbda_pkg::ST_DIGIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.one_left) begin
            state_nxt = sbda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sbda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/sbda_dp.sv
// Datapath: magnitude and BCD registers, counters and the output register.
`default_nettype none
module sbda_dp #(
  parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [VALUE_WIDTH-1:0]        in_value,
  input  wire sbda_pkg::ctrl_cmd_t           cmd,
  output sbda_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sbda_pkg::CHAR_W-1:0]        out_character,
  output logic                               out_last_char
);

  localparam int ND = sbda_pkg::dec_digits(VALUE_WIDTH);
  localparam int BW = 4 * ND;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam int DW = $clog2(ND + 1);

  logic [VALUE_WIDTH-1:0]       bin_r, bin_nxt;
  logic [BW-1:0]                bcd_r, bcd_nxt;
  logic [BW-1:0]                bcd_adj;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [DW-1:0]                dig_left_r, dig_left_nxt;
  logic                         neg_r, neg_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sbda_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [3:0]                   top_digit;

  assign top_digit = bcd_r[BW-1 -: 4];

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    dig_left_nxt  = dig_left_r;
    neg_nxt       = neg_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      neg_nxt      = in_value[VALUE_WIDTH-1];
      bin_nxt      = in_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~in_value + 1'b1) : in_value;
      bcd_nxt      = '0;
      cnt_nxt      = '0;
      dig_left_nxt = DW'(ND);
    end
    if (cmd.step) begin
      bcd_nxt = {bcd_adj[BW-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.skip || cmd.emit_digit) begin
      bcd_nxt      = {bcd_r[BW-5:0], 4'b0000};
      dig_left_nxt = dig_left_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = sbda_pkg::ASCII_MINUS;
      out_last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = sbda_pkg::ASCII_ZERO + {3'b000, top_digit};
      out_last_nxt  = (dig_left_r == DW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    dig_left_r <= dig_left_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.conv_done = (cnt_r == CW'(VALUE_WIDTH - 1));
  assign stat.top_zero  = (top_digit == 4'd0);
  assign stat.one_left  = (dig_left_r == DW'(1));
  assign stat.neg       = neg_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

endmodule
`default_nettype wire

>>> rtl/core/signed_binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
// Converts one signed VALUE_WIDTH-bit number into its decimal text, one ASCII character per
// output beat, most significant first, with a leading '-' for negative values and
// out_last_char set on the final digit. A number is accepted, then runs VALUE_WIDTH steps
// of the one-bit-per-cycle shift-add-3 loop, then skips leading zero digits one at a time,
// then sends a minus sign for negative values and the digits; output stalls hold those sends.
// Skipped and sent digits always number 19 together at VALUE_WIDTH 64. in_ready is high only
// between numbers; the final character may still sit in the output register while the next
// number is taken.
`default_nettype none
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [VALUE_WIDTH-1:0]        in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sbda_pkg::CHAR_W-1:0]        out_character,
  output logic                               out_last_char
);

  sbda_pkg::ctrl_cmd_t cmd;
  sbda_pkg::dp_stat_t  stat;

  sbda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbda_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  // only a minus sign or a decimal digit ever leaves the block
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == sbda_pkg::ASCII_MINUS) ||
                  ((out_character >= sbda_pkg::ASCII_ZERO) &&
                   (out_character <= sbda_pkg::ASCII_NINE)))
    else $error("illegal output character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_character == sbda_pkg::ASCII_MINUS)) |-> !out_last_char)
    else $error("minus sign flagged as last");

  // a new number is not taken straight after one has been accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted during conversion");

  a_no_emit_during_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !cmd.emit_digit && !cmd.emit_sign && !cmd.load)
    else $error("conversion overlaps output");

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the signed binary to decimal ASCII converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          VALUE_W         = 64;
  localparam logic [63:0] RADIX           = 64'd10;
  localparam int          TAIL_CYCLES     = 120;
  localparam int          DRAIN_LIMIT     = 20000;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          IDLE_PERCENT    = 18;
  localparam int          MAX_REPORTS     = 30;

  typedef struct {
    logic [sbda_pkg::CHAR_W-1:0] code;
    logic                        last;
    logic [VALUE_W-1:0]          source;
  } text_char_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic [VALUE_W-1:0]          in_value = '0;
  logic                        out_ready = 1'b0;
  logic                        in_ready;
  logic                        out_valid;
  logic [sbda_pkg::CHAR_W-1:0] out_character;
  logic                        out_last_char;

  text_char_t pending_chars[$];
  int         mismatch_count = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  bit         rx_hold = 1'b0;

  signed_binary_to_decimal_ascii DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last_char(out_last_char)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // decimal text of one number, most significant character first
  function automatic void predict_decimal_text(input logic [VALUE_W-1:0] value);
    logic [sbda_pkg::CHAR_W-1:0] rev[20];
    logic [VALUE_W-1:0]          mag;
    logic [VALUE_W-1:0]          rem;
    logic                        neg;
    int                          n;
    n = 0;
    neg = value[VALUE_W-1];
    mag = neg ? (~value + 1'b1) : value;
    if (mag == '0) begin
      rev[0] = sbda_pkg::ASCII_ZERO;
      n = 1;
    end
    while (mag != '0) begin
      rem = mag % RADIX;
      rev[n] = sbda_pkg::ASCII_ZERO + rem[sbda_pkg::CHAR_W-1:0];
      mag = mag / RADIX;
      n++;
    end
    if (neg) pending_chars.push_back('{sbda_pkg::ASCII_MINUS, 1'b0, value});
    for (int i = n - 1; i >= 0; i--) pending_chars.push_back('{rev[i], i == 0, value});
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    int                 sel;
    v = {$urandom, $urandom};
    sel = $urandom_range(0, 5);
    case (sel)
      1: v = v >> $urandom_range(0, 63);
      2: v = VALUE_W'($urandom_range(0, 999));
      3: begin
        p = 64'd1;
        repeat ($urandom_range(0, 18)) p = p * RADIX;
        v = p + VALUE_W'($urandom_range(0, 2)) - 64'd1;
      end
      4: v = 64'h7FFF_FFFF_FFFF_FFFF - VALUE_W'($urandom_range(0, 2));
      5: v = 64'h8000_0000_0000_0000 + VALUE_W'($urandom_range(0, 2));
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
    return v;
  endfunction

  // receiver: random stalls, or held off completely
  always @(negedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin : check_beat
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char %0d last %0b",
                                  out_character, out_last_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_character !== want.code)
          report_mismatch($sformatf("value %0d: char %0d, want %0d",
                                    $signed(want.source), out_character, want.code));
        if (out_last_char !== want.last)
          report_mismatch($sformatf("value %0d: last_char %0b, want %0b",
                                    $signed(want.source), out_last_char, want.last));
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_decimal_text(v);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_chars.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [VALUE_W-1:0] values[18] = '{
      64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd10, -64'd9, -64'd10,
      64'd99, 64'd100, 64'd123456789, 64'd999999999999999999,
      64'd1000000000000000000, -64'd1000000000000000000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
    };
    foreach (values[i]) send_value(values[i]);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (40) send_value(random_value());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // output held off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      repeat (6) send_value(random_value());
    join
  endtask

  task automatic test_drain_pause();
    repeat (10) begin
      send_value(random_value());
      stop_sending();
      wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(120);
    test_back_to_back();
    test_output_hold_off();
    test_drain_pause();
    test_random(110);
    stop_sending();
    wait_drained();
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    if (mismatch_count == 0) begin
      $display("signed_binary_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_binary_to_decimal_ascii regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("signed_binary_to_decimal_ascii regression: fail");
    $finish;
  end

endmodule

>>> signed_binary_to_decimal_ascii.f
rtl/core/sbda_pkg.sv
rtl/core/sbda_ctrl.sv
rtl/core/sbda_dp.sv
rtl/core/signed_binary_to_decimal_ascii.sv
tb/testbench.sv
